[design/symmetric_tensor_power_top_macros.svh]
// Assertion macros shared by the symmetric tensor power RTL.
`ifndef SYMMETRIC_TENSOR_POWER_TOP_MACROS_SVH
`define SYMMETRIC_TENSOR_POWER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checks the property at every clock edge outside of reset.
`define STP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checks the property at the clock edge after each edge at which reset is asserted.
`define STP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);
`else
`define STP_ASSERT(lbl, clk, rstn, prop, msg)
`define STP_ASSERT_RST(lbl, clk, rstn, prop, msg)
`endif
`endif

[design/stp_pkg.sv]
// Types, constants and helper functions for the symmetric tensor power block.
`default_nettype none
package stp_pkg;

	localparam int DATA_W           = 32;
	localparam int FRAC_W           = 16;
	localparam int EXP_W            = 4;
	localparam int PROD_W           = 2 * DATA_W;
	localparam int SHIFT_W          = PROD_W - FRAC_W;
	// Three shifted products summed exactly need two more bits.
	localparam int ACC_W            = SHIFT_W + 2;
	localparam int NUM_COMP         = 6;
	localparam int COMP_IDX_W       = 3;
	localparam int K_W              = 2;
	localparam int MAX_EXPONENT_DEF = 15;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Voigt component positions.
	localparam logic [COMP_IDX_W-1:0] C_XX = 3'd0;
	localparam logic [COMP_IDX_W-1:0] C_YY = 3'd1;
	localparam logic [COMP_IDX_W-1:0] C_ZZ = 3'd2;
	localparam logic [COMP_IDX_W-1:0] C_XY = 3'd3;
	localparam logic [COMP_IDX_W-1:0] C_YZ = 3'd4;
	localparam logic [COMP_IDX_W-1:0] C_XZ = 3'd5;

	typedef struct packed {
		logic signed [DATA_W-1:0] t_xx;
		logic signed [DATA_W-1:0] t_yy;
		logic signed [DATA_W-1:0] t_zz;
		logic signed [DATA_W-1:0] t_xy;
		logic signed [DATA_W-1:0] t_yz;
		logic signed [DATA_W-1:0] t_xz;
		logic [EXP_W-1:0]         exponent;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_xx;
		logic signed [DATA_W-1:0] out_yy;
		logic signed [DATA_W-1:0] out_zz;
		logic signed [DATA_W-1:0] out_xy;
		logic signed [DATA_W-1:0] out_yz;
		logic signed [DATA_W-1:0] out_xz;
		logic                     overflow;
	} out_t;

	// One multiply-accumulate request to the shared unit.
	typedef struct packed {
		logic                     vld;
		logic                     first;
		logic                     last;
		logic [COMP_IDX_W-1:0]    tag;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} mac_op_t;

	// One finished, saturated entry from the shared unit.
	typedef struct packed {
		logic                     vld;
		logic                     ovf;
		logic [COMP_IDX_W-1:0]    tag;
		logic signed [DATA_W-1:0] value;
	} mac_res_t;

	typedef struct packed {
		logic                     ovf;
		logic signed [DATA_W-1:0] value;
	} sat_t;

	// Voigt position of tensor element (r, c).
	function automatic logic [COMP_IDX_W-1:0] sym_idx(input logic [K_W-1:0] r,
			input logic [K_W-1:0] c);
		logic [COMP_IDX_W-1:0] idx;
		unique case ({r, c})
			4'b0000: idx = C_XX;
			4'b0101: idx = C_YY;
			4'b1010: idx = C_ZZ;
			4'b0001, 4'b0100: idx = C_XY;
			4'b0110, 4'b1001: idx = C_YZ;
			4'b0010, 4'b1000: idx = C_XZ;
			default: idx = C_XX;
		endcase
		return idx;
	endfunction

	// Row of the tensor element stored at a Voigt position.
	function automatic logic [K_W-1:0] row_of(input logic [COMP_IDX_W-1:0] e);
		logic [K_W-1:0] r;
		unique case (e)
			C_XX, C_XY, C_XZ: r = 2'd0;
			C_YY, C_YZ:       r = 2'd1;
			C_ZZ:             r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

	// Column of the tensor element stored at a Voigt position.
	function automatic logic [K_W-1:0] col_of(input logic [COMP_IDX_W-1:0] e);
		logic [K_W-1:0] c;
		unique case (e)
			C_XX:             c = 2'd0;
			C_YY, C_XY:       c = 2'd1;
			C_ZZ, C_YZ, C_XZ: c = 2'd2;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	// Clamps an accumulator value to the signed 32-bit range.
	function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
		sat_t s;
		logic [ACC_W-DATA_W:0] hi;
		hi = v[ACC_W-1:DATA_W-1];
		s.ovf = !((&hi) || !(|hi));
		if (s.ovf) begin
			s.value = v[ACC_W-1] ? Q_MIN : Q_MAX;
		end else begin
			s.value = v[DATA_W-1:0];
		end
		return s;
	endfunction

	// Doubles a value with saturation.
	function automatic sat_t sat_double(input logic signed [DATA_W-1:0] v);
		sat_t s;
		s.ovf = v[DATA_W-1] != v[DATA_W-2];
		if (s.ovf) begin
			s.value = v[DATA_W-1] ? Q_MIN : Q_MAX;
		end else begin
			s.value = {v[DATA_W-2:0], 1'b0};
		end
		return s;
	endfunction

endpackage
`default_nettype wire

[design/symmetric_tensor_power_top.sv]
// Top level of the symmetric tensor power block: sequencer, operand registers, output.
//
// Channel   Direction  Handshake              Payload
// input     in         start & !busy          operand  (stp_pkg::in_t)
// result    out        done, one-cycle strobe result   (stp_pkg::out_t)
// config    in         cfg_valid & cfg_ready  cfg_data (notation)
//
// Each iteration multiplies the running power by the tensor on one shared multiplier:
// 18 products issue back to back, the multiply and accumulate stages drain in the wait
// state and the copy state loads the new power. An item with exponent e runs e-1
// iterations; an exponent of 0 or 1 goes straight to the finishing state. busy stays
// high from acceptance until done and is low while done is high, so the next item can
// be accepted while done is high. Reset clears the notation register and the sequencer.
// The result register holds until the next item finishes; done marks it for one cycle.
`default_nettype none
`include "symmetric_tensor_power_top_macros.svh"
module symmetric_tensor_power_top #(
	parameter int MAX_EXPONENT = stp_pkg::MAX_EXPONENT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire stp_pkg::in_t   operand,
	output logic                done,
	output stp_pkg::out_t       result,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic           cfg_data
);

	localparam int CW = $clog2(MAX_EXPONENT + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_COPY  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t                             state_q;
	logic                               notation_q;
	logic signed [stp_pkg::DATA_W-1:0]  comp     [stp_pkg::NUM_COMP];
	logic signed [stp_pkg::DATA_W-1:0]  a_q      [stp_pkg::NUM_COMP];
	logic signed [stp_pkg::DATA_W-1:0]  p_q      [stp_pkg::NUM_COMP];
	logic signed [stp_pkg::DATA_W-1:0]  np_q     [stp_pkg::NUM_COMP];
	logic signed [stp_pkg::DATA_W-1:0]  fin_val  [stp_pkg::NUM_COMP];
	logic [stp_pkg::NUM_COMP-1:0]       fin_ovf;
	logic [CW-1:0]                      expo_c;
	logic [CW-1:0]                      iters_q;
	logic [stp_pkg::COMP_IDX_W-1:0]     e_q;
	logic [stp_pkg::K_W-1:0]            k_q;
	logic                               pass_q;
	logic                               ovf_q;
	logic                               done_q;
	stp_pkg::out_t                      result_q;
	stp_pkg::mac_op_t                   mac_op;
	stp_pkg::mac_res_t                  mac_res;
	stp_pkg::sat_t                      dbl      [stp_pkg::NUM_COMP];
	logic                               accept;

	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// Notation register, written by its own transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notation_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			notation_q <= cfg_data;
		end
	end

	// Input components as an array, and the clamped exponent.
	assign comp[stp_pkg::C_XX] = operand.t_xx;
	assign comp[stp_pkg::C_YY] = operand.t_yy;
	assign comp[stp_pkg::C_ZZ] = operand.t_zz;
	assign comp[stp_pkg::C_XY] = operand.t_xy;
	assign comp[stp_pkg::C_YZ] = operand.t_yz;
	assign comp[stp_pkg::C_XZ] = operand.t_xz;
	assign expo_c = (int'(operand.exponent) > MAX_EXPONENT) ? CW'(MAX_EXPONENT)
			: CW'(operand.exponent);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q     <= '0;
			k_q     <= '0;
			iters_q <= '0;
			pass_q  <= 1'b0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						e_q     <= '0;
						k_q     <= '0;
						ovf_q   <= 1'b0;
						iters_q <= expo_c - CW'(1);
						pass_q  <= expo_c <= CW'(1);
						state_q <= (expo_c <= CW'(1)) ? ST_FIN : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						if (e_q == stp_pkg::C_XZ) begin
							e_q     <= '0;
							state_q <= ST_WAIT;
						end else begin
							e_q <= e_q + 3'd1;
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_WAIT: begin
					if (mac_res.vld && mac_res.tag == stp_pkg::C_XZ) begin
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (iters_q == CW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						iters_q <= iters_q - CW'(1);
						state_q <= ST_ISSUE;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (mac_res.vld && mac_res.ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Operand registers: the base tensor, the running power and the next power.
	always_ff @(posedge clk) begin
		for (int n = 0; n < stp_pkg::NUM_COMP; n++) begin
			if (accept) begin
				if (n >= 3 && notation_q && expo_c > CW'(1)) begin
					a_q[n] <= comp[n] >>> 1;
					p_q[n] <= comp[n] >>> 1;
				end else begin
					a_q[n] <= comp[n];
					p_q[n] <= comp[n];
				end
			end else if (state_q == ST_COPY) begin
				p_q[n] <= np_q[n];
			end
		end
		if (mac_res.vld) begin
			np_q[mac_res.tag] <= mac_res.value;
		end
	end

	// Request to the shared unit: P[row][k] times A[k][col].
	assign mac_op.vld   = state_q == ST_ISSUE;
	assign mac_op.first = k_q == 2'd0;
	assign mac_op.last  = k_q == 2'd2;
	assign mac_op.tag   = e_q;
	assign mac_op.a     = p_q[stp_pkg::sym_idx(stp_pkg::row_of(e_q), k_q)];
	assign mac_op.b     = a_q[stp_pkg::sym_idx(k_q, stp_pkg::col_of(e_q))];

	stp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.res    (mac_res)
	);

	// Final values: shear terms doubled back in strain notation.
	always_comb begin
		for (int n = 0; n < stp_pkg::NUM_COMP; n++) begin
			dbl[n] = stp_pkg::sat_double(p_q[n]);
			if (!pass_q && notation_q && n >= 3) begin
				fin_val[n] = dbl[n].value;
				fin_ovf[n] = dbl[n].ovf;
			end else begin
				fin_val[n] = p_q[n];
				fin_ovf[n] = 1'b0;
			end
		end
	end

	// Result register, loaded as the item finishes.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			result_q.out_xx   <= fin_val[stp_pkg::C_XX];
			result_q.out_yy   <= fin_val[stp_pkg::C_YY];
			result_q.out_zz   <= fin_val[stp_pkg::C_ZZ];
			result_q.out_xy   <= fin_val[stp_pkg::C_XY];
			result_q.out_yz   <= fin_val[stp_pkg::C_YZ];
			result_q.out_xz   <= fin_val[stp_pkg::C_XZ];
			result_q.overflow <= !pass_q && (ovf_q || (|fin_ovf));
		end
	end

	`STP_ASSERT(a_done_after_fin, clk, arst_n, done |-> $past(state_q == ST_FIN), "done without a finishing cycle")
	`STP_ASSERT(a_res_in_iter, clk, arst_n, mac_res.vld |-> (state_q == ST_ISSUE || state_q == ST_WAIT), "entry result outside an iteration")
	`STP_ASSERT(a_no_issue_idle, clk, arst_n, !busy |-> !mac_op.vld, "product issued while idle")
	`STP_ASSERT_RST(a_quiet_in_reset, clk, arst_n, !busy && !done, "activity during reset")

endmodule
`default_nettype wire

[design/stp_mac.sv]
// Shared multiply-accumulate unit: one 32x32 product per cycle, shifted and summed.
`default_nettype none
`include "symmetric_tensor_power_top_macros.svh"
module stp_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stp_pkg::mac_op_t  op,
	output stp_pkg::mac_res_t      res
);

	logic signed [stp_pkg::PROD_W-1:0]  prod_s1;
	logic                               vld_s1;
	logic                               first_s1;
	logic                               last_s1;
	logic [stp_pkg::COMP_IDX_W-1:0]     tag_s1;
	logic signed [stp_pkg::SHIFT_W-1:0] shifted;
	logic signed [stp_pkg::ACC_W-1:0]   acc_base;
	logic signed [stp_pkg::ACC_W-1:0]   acc_nx;
	logic signed [stp_pkg::ACC_W-1:0]   acc_q;
	stp_pkg::sat_t                      sat;
	logic                               vld_s2;
	logic                               ovf_s2;
	logic [stp_pkg::COMP_IDX_W-1:0]     tag_s2;
	logic signed [stp_pkg::DATA_W-1:0]  value_s2;

	// Stage one: the exact signed product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= op.a * op.b;
		first_s1 <= op.first;
		last_s1  <= op.last;
		tag_s1   <= op.tag;
	end

	// Stage two: floor shift by the fraction width, then accumulate.
	assign shifted  = prod_s1[stp_pkg::PROD_W-1:stp_pkg::FRAC_W];
	assign acc_base = first_s1 ? '0 : acc_q;
	assign acc_nx   = acc_base + stp_pkg::ACC_W'(shifted);
	assign sat      = stp_pkg::sat_acc(acc_nx);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_nx;
		end
		ovf_s2   <= sat.ovf;
		tag_s2   <= tag_s1;
		value_s2 <= sat.value;
	end

	// A finished entry leaves after its third product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && last_s1;
		end
	end

	assign res.vld   = vld_s2;
	assign res.ovf   = ovf_s2;
	assign res.tag   = tag_s2;
	assign res.value = value_s2;

	`STP_ASSERT(a_res_from_last, clk, arst_n, res.vld |-> $past(op.vld && op.last, 2), "result without a closing product")
	`STP_ASSERT(a_s1_from_op, clk, arst_n, vld_s1 |-> $past(op.vld), "stage one valid without a request")

endmodule
`default_nettype wire

[verif/tb_symmetric_tensor_power_top.sv]
// Self-checking testbench for the symmetric tensor power block with its own Q16.16 predictor.
module tb_symmetric_tensor_power_top;

	localparam int RUN_LIMIT    = 3_000_000;
	localparam int RANDOM_ITEMS = 1930;
	localparam int NUM_PHASES   = 6;
	localparam int MAX_POWER    = stp_pkg::MAX_EXPONENT_DEF;
	localparam int DW           = stp_pkg::DATA_W;
	// Longest time from acceptance to done is well under this.
	localparam int SETTLE_CYCLES = 320;

	localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;
	localparam logic signed [DW-1:0] HALF = 32'sh0000_8000;
	localparam logic signed [DW-1:0] Q_HI = stp_pkg::Q_MAX;
	localparam logic signed [DW-1:0] Q_LO = stp_pkg::Q_MIN;

	localparam bit STRESS = 1'b0;
	localparam bit STRAIN = 1'b1;

	// Voigt position of each tensor element.
	localparam int VOIGT [3][3] = '{
		'{stp_pkg::C_XX, stp_pkg::C_XY, stp_pkg::C_XZ},
		'{stp_pkg::C_XY, stp_pkg::C_YY, stp_pkg::C_YZ},
		'{stp_pkg::C_XZ, stp_pkg::C_YZ, stp_pkg::C_ZZ}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	stp_pkg::in_t operand = '0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	logic busy;
	logic done;
	logic cfg_ready;
	stp_pkg::out_t result;

	// Expected powers in acceptance order, the notation in force, and bookkeeping.
	stp_pkg::out_t power_q[$];
	bit strain_mode = STRESS;
	bit burst_mode = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	symmetric_tensor_power_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operand  (operand),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clamps a wide value to the signed 32-bit range and notes any clamping.
	function automatic longint clamp_q(input longint v, inout bit ovf);
		if (v > longint'(Q_HI)) begin
			ovf = 1'b1;
			return longint'(Q_HI);
		end
		if (v < longint'(Q_LO)) begin
			ovf = 1'b1;
			return longint'(Q_LO);
		end
		return v;
	endfunction

	// Raises the tensor to its exponent in Q16.16, shear terms in the given notation.
	function automatic stp_pkg::out_t tensor_power(input stp_pkg::in_t it, input bit strain);
		longint src[6];
		longint a[6];
		longint pw[6];
		longint acc[6];
		longint res[6];
		int e;
		int rnd;
		int i;
		int j;
		int k;
		int n;
		bit ovf;
		stp_pkg::out_t r;
		src[stp_pkg::C_XX] = longint'($signed(it.t_xx));
		src[stp_pkg::C_YY] = longint'($signed(it.t_yy));
		src[stp_pkg::C_ZZ] = longint'($signed(it.t_zz));
		src[stp_pkg::C_XY] = longint'($signed(it.t_xy));
		src[stp_pkg::C_YZ] = longint'($signed(it.t_yz));
		src[stp_pkg::C_XZ] = longint'($signed(it.t_xz));
		e = int'(it.exponent);
		if (e > MAX_POWER)
			e = MAX_POWER;
		ovf = 1'b0;
		if (e <= 1) begin
			res = src;
		end else begin
			// Strain shear terms are halved toward minus infinity first.
			for (n = 0; n < 6; n++) begin
				a[n] = src[n];
				if (n >= stp_pkg::C_XY && strain)
					a[n] = src[n] >>> 1;
			end
			pw = a;
			for (rnd = 1; rnd < e; rnd++) begin
				acc = '{default: 0};
				for (i = 0; i < 3; i++)
					for (j = i; j < 3; j++)
						for (k = 0; k < 3; k++)
							acc[VOIGT[i][j]] += (pw[VOIGT[i][k]] * a[VOIGT[k][j]])
								>>> stp_pkg::FRAC_W;
				for (n = 0; n < 6; n++)
					pw[n] = clamp_q(acc[n], ovf);
			end
			for (n = 0; n < 6; n++) begin
				res[n] = pw[n];
				if (n >= stp_pkg::C_XY && strain)
					res[n] = clamp_q(pw[n] * 2, ovf);
			end
		end
		r.out_xx   = res[stp_pkg::C_XX][DW-1:0];
		r.out_yy   = res[stp_pkg::C_YY][DW-1:0];
		r.out_zz   = res[stp_pkg::C_ZZ][DW-1:0];
		r.out_xy   = res[stp_pkg::C_XY][DW-1:0];
		r.out_yz   = res[stp_pkg::C_YZ][DW-1:0];
		r.out_xz   = res[stp_pkg::C_XZ][DW-1:0];
		r.overflow = ovf;
		return r;
	endfunction

	function automatic stp_pkg::in_t make_tensor(input logic signed [DW-1:0] xx, yy, zz,
			xy, yz, xz, input int e);
		stp_pkg::in_t it;
		it.t_xx     = xx;
		it.t_yy     = yy;
		it.t_zz     = zz;
		it.t_xy     = xy;
		it.t_yz     = yz;
		it.t_xz     = xz;
		it.exponent = e[stp_pkg::EXP_W-1:0];
		return it;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One component: boundary values now and then, otherwise a value of the given scale.
	function automatic logic signed [DW-1:0] rand_comp(input int scale);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 7))
				0: return Q_HI;
				1: return Q_LO;
				2: return '0;
				3: return -1;
				4: return 1;
				5: return ONE;
				6: return -ONE;
				default: return HALF;
			endcase
		end
		case (scale)
			0: return int'($urandom_range(0, 196608)) - 98304;
			1: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
			default: return $urandom;
		endcase
	endfunction

	function automatic stp_pkg::in_t rand_tensor();
		int scale;
		int e;
		scale = $urandom_range(0, 99);
		scale = (scale < 50) ? 0 : ((scale < 75) ? 1 : 2);
		e = ($urandom_range(0, 9) < 7) ? $urandom_range(0, MAX_POWER) : $urandom_range(2, 4);
		return make_tensor(rand_comp(scale), rand_comp(scale), rand_comp(scale),
			rand_comp(scale), rand_comp(scale), rand_comp(scale), e);
	endfunction

	// Presents one tensor and waits until the block takes it.
	task automatic send_tensor(input stp_pkg::in_t it);
		int gap;
		gap = burst_mode ? 0 : idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operand <= it;
		do @(posedge clk); while (busy !== 1'b0);
		power_q.push_back(tensor_power(it, strain_mode));
	endtask

	// Stops issuing and waits for every outstanding power.
	task automatic drain();
		start <= 1'b0;
		while (power_q.size() != 0)
			@(posedge clk);
	endtask

	// Writes the notation register while the block is idle.
	task automatic write_notation(input bit value);
		drain();
		repeat ($urandom_range(1, 6)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		strain_mode = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [DW-1:0] want, got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("mismatch on %s: expected %08h actual %08h", name, want, got);
			mismatches++;
		end
	endtask

	// Stress notation straight out of reset: pass-through, saturation and decay cases.
	task automatic test_reset_stress();
		send_tensor(make_tensor(0, 0, 0, 0, 0, 0, 0));
		send_tensor(make_tensor(ONE, ONE, ONE, 0, 0, 0, 15));
		send_tensor(make_tensor(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, 0));
		send_tensor(make_tensor(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, 1));
		send_tensor(make_tensor(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, 2));
		send_tensor(make_tensor(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, 15));
		send_tensor(make_tensor(-1, -1, -1, -1, -1, -1, 2));
		send_tensor(make_tensor(ONE, ONE, ONE, HALF, HALF, HALF, 3));
		send_tensor(make_tensor(-ONE, ONE, -ONE, -HALF, HALF, -1, 4));
		send_tensor(make_tensor(HALF, HALF, HALF, HALF, HALF, HALF, 15));
		send_tensor(make_tensor(Q_HI, Q_LO, 0, 1, -1, ONE, 2));
		send_tensor(make_tensor(3 * ONE, -2 * ONE, ONE, -ONE, 2 * ONE, HALF, 7));
	endtask

	// Strain notation: odd negative shears, pass-through without scaling, doubling overflow.
	task automatic test_strain_directed();
		write_notation(STRAIN);
		send_tensor(make_tensor(ONE, ONE, ONE, -1, -3, Q_HI, 2));
		send_tensor(make_tensor(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, 0));
		send_tensor(make_tensor(Q_HI, Q_HI, Q_HI, -1, -3, 5, 1));
		send_tensor(make_tensor(ONE, ONE, 0, 32'sh6000_0000, 0, 0, 2));
		send_tensor(make_tensor(ONE, ONE, ONE, -2, -2, -2, 15));
		send_tensor(make_tensor(0, 0, 0, 0, 0, 0, 2));
		send_tensor(make_tensor(HALF, -HALF, HALF, ONE, -ONE, 3, 15));
		send_tensor(make_tensor(Q_LO, Q_HI, -1, Q_LO, Q_HI, -ONE, 2));
		send_tensor(make_tensor(2 * ONE, ONE, -ONE, 2 * ONE, -ONE, ONE, 9));
	endtask

	// Random tensors in phases that switch notation, one phase issued back to back.
	task automatic test_random_mix();
		bit order [NUM_PHASES];
		int ph;
		int n;
		order = '{STRESS, STRAIN, STRESS, STRAIN, STRESS, STRAIN};
		order[4] = $urandom_range(0, 1);
		order[5] = $urandom_range(0, 1);
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_notation(order[ph]);
			burst_mode = (ph == 3);
			for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
				send_tensor(rand_tensor());
		end
		burst_mode = 1'b0;
	endtask

	// Each done strobe is checked against the oldest expected power.
	always @(posedge clk) begin
		stp_pkg::out_t want;
		if (arst_n && done === 1'b1) begin
			if (power_q.size() == 0) begin
				if (mismatches < 10)
					$display("result transaction with nothing expected: %h", result);
				mismatches++;
			end else begin
				want = power_q.pop_front();
				compare_field("out_xx", want.out_xx, result.out_xx);
				compare_field("out_yy", want.out_yy, result.out_yy);
				compare_field("out_zz", want.out_zz, result.out_zz);
				compare_field("out_xy", want.out_xy, result.out_xy);
				compare_field("out_yz", want.out_yz, result.out_yz);
				compare_field("out_xz", want.out_xz, result.out_xz);
				compare_field("overflow", 32'(want.overflow), 32'(result.overflow));
			end
		end
	end

	// Ends a run that hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb_symmetric_tensor_power_top failed");
			$finish;
		end
	end

	// Reset once, then the tests in turn, then the verdict.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_stress();
		test_strain_directed();
		test_random_mix();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += power_q.size();
		if (mismatches == 0) begin
			$display("tb_symmetric_tensor_power_top passed");
		end else begin
			$display("tb_symmetric_tensor_power_top failed");
		end
		$finish;
	end

endmodule
